// ===== design/debounced_pulse_rate_meter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Pulse rate meter assertion macros
// Shared property macros for the checker of the pulse rate meter.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PULSE_RATE_METER_UNIT_DEFINES_SVH
`define DEBOUNCED_PULSE_RATE_METER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held
`define DPRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pulse rate meter check failed");

// Next-cycle implication, sampled on clk, off while reset is held
`define DPRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pulse rate meter check failed");

`endif

// ===== design/dprm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter package
// Widths, operation codes, scale constants and shared types.
// ----------------------------------------------------------------------------
package dprm_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 20;
  localparam int RATE_W   = 56;
  localparam int SCALE_W  = 16;
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = CNT_W + SCALE_W;

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd0;
  localparam logic [OP_W-1:0] OP_RD_SEC = 2'd1;
  localparam logic [OP_W-1:0] OP_RD_MIN = 2'd2;

  // Rate scale factors
  localparam logic [SCALE_W-1:0] SCALE_SEC = 16'd1000;
  localparam logic [SCALE_W-1:0] SCALE_MIN = 16'd60000;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESULT
  } dprm_state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== design/dprm_if.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter channels
// Valid/ready channels for event requests and rate results.
// ----------------------------------------------------------------------------

// Event request channel
interface dprm_in_if;
  import dprm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TIME_W-1:0] now_us;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, operation, now_us, now_ms, input ready);
  modport sink   (input valid, operation, now_us, now_ms, output ready);
endinterface

// Rate result channel
interface dprm_out_if;
  import dprm_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_q8;
  logic              elapsed_zero;

  modport source (output valid, rate_q8, elapsed_zero, input ready);
  modport sink   (input valid, rate_q8, elapsed_zero, output ready);
endinterface

// ===== design/debounced_pulse_rate_meter_unit.sv =====
// Edge request: taken whenever the block is idle, edges may come back to back.
// Read request: 56-step serial divide, then the output load once it is free.
// A read blocks new requests until its result sits in the output register.
// Throughput is set by the one-bit-per-cycle divider and the output load.
// Synchronous active-low reset clears count, edge/read times, config and valids.
// ----------------------------------------------------------------------------
// Debounced pulse rate meter
// Debounced edge counter with a per-second or per-minute rate readout.
// ----------------------------------------------------------------------------
module debounced_pulse_rate_meter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dprm_pkg::CFG_W-1:0] cfg_wdata,
  dprm_in_if.sink                    in_ch,
  dprm_out_if.source                 out_ch
);
  import dprm_pkg::*;

  dprm_state_t       state_r;
  dprm_state_t       state_nxt;
  logic [TIME_W-1:0] last_report_r;
  logic              zero_r;
  logic              out_valid_r;
  logic [RATE_W-1:0] out_rate_r;
  logic              out_zero_r;

  logic              in_acc;
  logic              rd_acc;
  logic              edge_en;
  logic              div_start;
  logic              load_out;
  logic [CNT_W-1:0]  count;
  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0] prod;
  logic [RATE_W-1:0] numer;
  logic [TIME_W-1:0] elapsed;
  logic [RATE_W-1:0] quotient;
  div_sts_t          div_sts;

  // Request decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign edge_en     = in_acc && (in_ch.operation == OP_EDGE);
  assign rd_acc      = in_acc && ((in_ch.operation == OP_RD_SEC) ||
                                  (in_ch.operation == OP_RD_MIN));

  // Numerator count*scale in Q.8, elapsed ms since last read
  assign scale   = (in_ch.operation == OP_RD_MIN) ? SCALE_MIN : SCALE_SEC;
  assign prod    = PROD_W'(count) * PROD_W'(scale);
  assign numer   = {prod, {FRAC_W{1'b0}}};
  assign elapsed = in_ch.now_ms - last_report_r;

  dprm_edge u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .edge_en   (edge_en),
    .now_us    (in_ch.now_us),
    .clr       (rd_acc),
    .count     (count)
  );

  dprm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (numer),
    .divisor  (elapsed),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (rd_acc) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer and read-time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_report_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rd_acc) begin
        last_report_r <= in_ch.now_ms;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      zero_r <= (elapsed == '0);
    end
    if (load_out) begin
      out_rate_r <= zero_r ? '0 : quotient;
      out_zero_r <= zero_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rate_q8      = out_rate_r;
  assign out_ch.elapsed_zero = out_zero_r;

endmodule

// ===== design/dprm_edge.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter edge filter
// Debounces rising edges against the last accepted edge and counts them.
// ----------------------------------------------------------------------------
module dprm_edge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dprm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        edge_en,
  input  logic [dprm_pkg::TIME_W-1:0] now_us,
  input  logic                        clr,
  output logic [dprm_pkg::CNT_W-1:0]  count
);
  import dprm_pkg::*;

  logic [CFG_W-1:0]  min_gap_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [TIME_W-1:0] last_edge_r;
  logic [TIME_W-1:0] gap;
  logic              take;

  // Gap since last accepted edge, modulo wrap
  assign gap  = now_us - last_edge_r;
  assign take = edge_en && (gap > {{(TIME_W-CFG_W){1'b0}}, min_gap_r});

  // Saturating count, cleared by a read
  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (take && (count_r != {CNT_W{1'b1}})) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r   <= '0;
      count_r     <= '0;
      last_edge_r <= '0;
    end else begin
      if (cfg_we) begin
        min_gap_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (take) begin
        last_edge_r <= now_us;
      end
    end
  end

  assign count = count_r;

endmodule

// ===== design/dprm_div.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter serial divider
// Restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module dprm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dprm_pkg::RATE_W-1:0] dividend,
  input  logic [dprm_pkg::TIME_W-1:0] divisor,
  output dprm_pkg::div_sts_t          sts,
  output logic [dprm_pkg::RATE_W-1:0] quotient
);
  import dprm_pkg::*;

  logic [RATE_W-1:0]    dvd_r;
  logic [TIME_W-1:0]    dsr_r;
  logic [TIME_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 qbit;

  // Shift in next dividend bit and try the subtract
  assign trial = {rem_r, dvd_r[RATE_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = !diff[TIME_W];

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      dvd_r <= {dvd_r[RATE_W-2:0], qbit};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dvd_r;

endmodule

// ===== design/dprm_chk.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter checker
// Port-level checks on the pulse rate meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "debounced_pulse_rate_meter_unit_defines.svh"

module dprm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [dprm_pkg::OP_W-1:0]   in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dprm_pkg::RATE_W-1:0] out_rate,
  input logic                        out_zero
);
  import dprm_pkg::*;

  logic in_acc;
  logic rd_req;

  assign in_acc = in_valid && in_ready;
  assign rd_req = (in_op == OP_RD_SEC) || (in_op == OP_RD_MIN);

  // Stalled result holds
  `DPRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rate))

  // A read occupies the block
  `DPRM_ASSERT_NEXT(a_read_busy, in_acc && rd_req, !in_ready)

  // Edges and unused codes never stall the request side
  `DPRM_ASSERT_NEXT(a_edge_free, in_acc && !rd_req, in_ready)

  // Zero elapsed time reports a zero rate
  `DPRM_ASSERT_NOW(a_zero_rate, out_valid && out_zero, out_rate == '0)

endmodule

bind debounced_pulse_rate_meter_unit dprm_chk u_dprm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.operation),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rate  (out_ch.rate_q8),
  .out_zero  (out_ch.elapsed_zero)
);

// ===== tb/debounced_pulse_rate_meter_unit_test.sv =====
// ----------------------------------------------------------------------------
// Pulse rate meter testbench
// Drives edge and read requests through the valid/ready channels, predicts
// every rate result from a local model of the debounce and divide, and
// compares each result field by field under several debounce windows and
// idle/stall patterns on both sides.
// ----------------------------------------------------------------------------
module debounced_pulse_rate_meter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dprm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS   = 190;

  localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
  localparam logic [CFG_W-1:0] INTERVAL_MAX  = '1;
  localparam logic [63:0]      PER_SECOND    = 64'd1000;
  localparam logic [63:0]      PER_MINUTE    = 64'd60000;
  localparam int unsigned      FRACTION_BITS = 8;

  // Predicts rate results from accepted requests and checks them in order
  class rate_tracker;
    typedef struct packed {
      logic [RATE_W-1:0] rate_q8;
      logic              elapsed_zero;
    } rate_t;

    logic [CFG_W-1:0]  min_interval_us;
    logic [CNT_W-1:0]  pulse_count;
    logic [TIME_W-1:0] last_edge_us;
    logic [TIME_W-1:0] last_report_ms;
    rate_t             expected_rates[$];
    int unsigned       errors;

    function new();
      min_interval_us = '0;
      pulse_count     = '0;
      last_edge_us    = '0;
      last_report_ms  = '0;
      errors          = 0;
    endfunction

    function void set_min_interval(input logic [CFG_W-1:0] value);
      min_interval_us = value;
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction

    function void note_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_us,
                               input logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       scale;
      logic [63:0]       numerator;
      rate_t             rate;
      case (op)
        OP_EDGE: begin
          // debounce: only a gap strictly wider than the window counts
          gap = now_us - last_edge_us;
          if (gap > 32'(min_interval_us)) begin
            if (pulse_count != '1) pulse_count++;
            last_edge_us = now_us;
          end
        end
        OP_RD_SEC, OP_RD_MIN: begin
          scale             = (op == OP_RD_SEC) ? PER_SECOND : PER_MINUTE;
          elapsed           = now_ms - last_report_ms;
          rate.elapsed_zero = (elapsed == '0);
          rate.rate_q8      = '0;
          if (elapsed != '0) begin
            numerator    = ({32'b0, pulse_count} * scale) << FRACTION_BITS;
            rate.rate_q8 = RATE_W'(numerator / {32'b0, elapsed});
          end
          pulse_count    = '0;
          last_report_ms = now_ms;
          expected_rates.push_back(rate);
        end
        default: ;  // unused code: no state change, no result
      endcase
    endfunction

    function void check_rate(input logic [RATE_W-1:0] rate_q8, input logic elapsed_zero);
      rate_t want;
      if (expected_rates.size() == 0) begin
        $error("unexpected result: rate_q8 %0d elapsed_zero %0b", rate_q8, elapsed_zero);
        errors++;
      end else begin
        want = expected_rates.pop_front();
        if (want.rate_q8 !== rate_q8) begin
          $error("rate_q8 mismatch: expected %0d, actual %0d", want.rate_q8, rate_q8);
          errors++;
        end
        if (want.elapsed_zero !== elapsed_zero) begin
          $error("elapsed_zero mismatch: expected %0b, actual %0b",
                 want.elapsed_zero, elapsed_zero);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  dprm_in_if  in_ch();
  dprm_out_if out_ch();

  debounced_pulse_rate_meter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rate_tracker       tracker            = new();
  int unsigned       sender_idle_pct    = 0;
  int unsigned       receiver_stall_pct = 0;
  int unsigned       cycle_count        = 0;
  logic [CFG_W-1:0]  cur_interval       = '0;
  logic [TIME_W-1:0] clock_us           = '0;
  logic [TIME_W-1:0] clock_ms           = '0;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("debounced_pulse_rate_meter_unit_test NOT OK");
      $finish;
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Handshake monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_request(in_ch.operation, in_ch.now_us, in_ch.now_ms);
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_rate(out_ch.rate_q8, out_ch.elapsed_zero);
  end

  // Present one request, hold it until accepted, then maybe idle
  task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_us,
                              input logic [TIME_W-1:0] now_ms);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.now_us    <= now_us;
    in_ch.now_ms    <= now_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < sender_idle_pct) @(posedge clk);
    end
  endtask

  // Stop sending, let every expected result drain, then let the block settle
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    // let the monitor log the last accepted request before polling the queue
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_interval(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_min_interval(value);
    cur_interval = value;
  endtask

  // One random request on a running timebase; gaps cluster around the window
  task automatic random_item(output bit counted);
    int unsigned       pick;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] window;
    logic [OP_W-1:0]   read_op;
    window  = 32'(cur_interval);
    pick    = $urandom_range(0, 99);
    read_op = $urandom_range(0, 1) ? OP_RD_MIN : OP_RD_SEC;
    counted = 1'b1;
    if (pick < 3) begin
      counted = 1'b0;
      send_request(OP_UNUSED, $urandom(), $urandom());
    end else if (pick < 6) begin
      // timebase jumps anywhere
      clock_us = $urandom();
      clock_ms = $urandom();
      send_request($urandom_range(0, 1) ? OP_EDGE : read_op, clock_us, clock_ms);
    end else if (pick < 84) begin
      case ($urandom_range(0, 6))
        0:       step = window;
        1:       step = window + 1;
        2:       step = $urandom_range(0, window);
        3:       step = window + $urandom_range(2, 5000);
        4:       step = '0;
        5:       step = $urandom();
        default: step = window + 1 + $urandom_range(0, window);
      endcase
      clock_us += step;
      send_request(OP_EDGE, clock_us, clock_ms);
    end else begin
      case ($urandom_range(0, 4))
        0:       step = '0;
        1:       step = 1;
        2:       step = $urandom_range(2, 1000);
        3:       step = $urandom_range(1001, 200000);
        default: step = $urandom();
      endcase
      clock_ms += step;
      send_request(read_op, clock_us, clock_ms);
    end
  endtask

  // Stimulus
  initial begin
    int unsigned phase_items;
    bit          counted;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_EDGE;
    in_ch.now_us    <= '0;
    in_ch.now_ms    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: window 0, wrap of both timebases, zero elapsed time
    write_min_interval('0);
    send_request(OP_EDGE, 32'd0, '1);          // zero gap from reset time
    send_request(OP_EDGE, 32'd1, 32'd0);
    send_request(OP_EDGE, 32'd1, 32'd0);       // repeat time, dropped
    send_request(OP_EDGE, '1, 32'd0);
    send_request(OP_EDGE, 32'd0, 32'd0);       // gap of one across the wrap
    send_request(OP_RD_SEC, 32'd0, 32'd0);     // no time since reset
    send_request(OP_EDGE, 32'd5, 32'd0);
    send_request(OP_EDGE, 32'd6, 32'd0);
    send_request(OP_RD_MIN, 32'd6, 32'd1);     // one millisecond, largest scale
    send_request(OP_RD_SEC, 32'd6, 32'd1);     // back-to-back read, zero elapsed
    send_request(OP_RD_SEC, '1, '1);           // empty count, near-full interval
    send_request(OP_EDGE, 32'd100, 32'd0);
    send_request(OP_RD_MIN, 32'd100, 32'd0);   // interval wraps to one
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_UNUSED, 32'd0, 32'd0);

    // Directed: widest window, gap exactly at and just past it
    wait_for_results();
    write_min_interval(INTERVAL_MAX);
    send_request(OP_EDGE, 32'd100 + 32'(INTERVAL_MAX), 32'd0);
    send_request(OP_EDGE, 32'd101 + 32'(INTERVAL_MAX), 32'd0);
    send_request(OP_EDGE, 32'd102 + 2 * 32'(INTERVAL_MAX), 32'd0);
    send_request(OP_RD_SEC, 32'd0, 32'd1000);

    // Random phases over windows and idle patterns
    clock_us = $urandom();
    clock_ms = $urandom();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0:       write_min_interval('0);
        1:       write_min_interval(INTERVAL_MAX);
        2:       write_min_interval(CFG_W'($urandom_range(1, 1000)));
        4:       write_min_interval(CFG_W'(1));
        5:       write_min_interval(CFG_W'(1_000_000));
        default: write_min_interval(CFG_W'($urandom()));
      endcase
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) begin
          phase_items++;
          // mid-phase hold-off until the result queue is empty
          if (phase == 2 && phase_items == PHASE_ITEMS / 2) wait_for_results();
        end
      end
    end

    wait_for_results();
    if (tracker.errors == 0) begin
      $display("debounced_pulse_rate_meter_unit_test OK");
    end else begin
      $display("debounced_pulse_rate_meter_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/dprm_pkg.sv
design/dprm_if.sv
design/dprm_edge.sv
design/dprm_div.sv
design/debounced_pulse_rate_meter_unit.sv
design/dprm_chk.sv
tb/debounced_pulse_rate_meter_unit_test.sv
